// File: sv/bdot_rate_estimator_top_defines.svh
// Assertion macros used by the port-level checker.
`ifndef BDOT_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define BDOT_RATE_ESTIMATOR_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define BRE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/bdot_pkg.sv
// Shared types and constants of the field rate estimator.
package bdot_pkg;
  localparam logic [1:0] ST_PRIMED  = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_BADTIME = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;
  localparam logic [0:0] KIND_SAMPLE = 1'b0;
  localparam logic [0:0] KIND_CLEAR  = 1'b1;
  localparam logic [31:0] E1_Q30 = 32'd395007542;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  typedef struct packed {
    logic [0:0]         kind;
    logic [31:0]        sample_time;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        estimate_time;
    logic signed [31:0] raw_rate_x;
    logic signed [31:0] raw_rate_y;
    logic signed [31:0] raw_rate_z;
    logic signed [31:0] smooth_rate_x;
    logic signed [31:0] smooth_rate_y;
    logic signed [31:0] smooth_rate_z;
  } out_item_t;

  // Request to the shared divider: start strobe, dividend and divisor.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

// File: sv/bdot_in_if.sv
// Valid/ready channel carrying one input item.
interface bdot_in_if;
  logic valid;
  logic ready;
  bdot_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/bdot_out_if.sv
// Valid/ready channel carrying one result item.
interface bdot_out_if;
  logic valid;
  logic ready;
  bdot_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/bdot_rate_estimator_top.sv
// Top level of the magnetic field rate estimator.
// A clear, a first sample or a stale timestamp gives its result the cycle after the transfer.
// For an estimate the shared divider runs once for the weight, unless the time constant is zero,
// and once per axis; between them come the Taylor series and the powers of exp(-1).
// One item is in work at a time; ready returns the cycle after the result is taken.
// Reset clears all stored samples, the estimate and the time constant.
module bdot_rate_estimator_top #(
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bdot_in_if.sink     in_if,
  bdot_out_if.source  out_if
);
  localparam int F = WEIGHT_FRAC_BITS;
  localparam logic [63:0] TPS = 64'(TICKS_PER_SECOND);
  localparam logic [63:0] ONE_W = 64'(1) << F;

  typedef enum logic [3:0] {
    S_IDLE, S_WDIV, S_WDIV_W, S_TAYLOR_MUL, S_TAYLOR_DIV,
    S_EXP_MUL, S_RDIV, S_RDIV_W, S_BLEND1, S_BLEND2, S_OUT
  } state_e;

  state_e state_q;
  logic [31:0] tc_q;
  logic have_prev_q, have_est_q;
  logic [31:0] prev_time_q;
  logic signed [23:0] prev_f_q [3];
  logic signed [31:0] last_s_q [3];
  bdot_pkg::in_item_t item_q;
  logic [31:0] ival_q;
  logic [63:0] x_q, term_q, acc_q;
  logic signed [63:0] sum_q;
  logic [3:0] k_q;
  logic [5:0] n_q;
  logic [1:0] ax_q;
  logic [F:0] w_q;
  logic signed [31:0] raw_q [3];
  logic signed [31:0] sm_q [3];
  logic neg_q;
  logic signed [63:0] bl_q;
  bdot_pkg::div_req_t dreq;
  logic ddone;
  logic [63:0] dquot;

  bdot_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  logic signed [24:0] diff;
  logic [24:0] mag;
  logic signed [23:0] fsel;
  always_comb begin
    unique case (ax_q)
      2'd0: fsel = item_q.field_x;
      2'd1: fsel = item_q.field_y;
      default: fsel = item_q.field_z;
    endcase
    diff = 25'(fsel) - 25'(prev_f_q[ax_q]);
    mag = diff[24] ? 25'(-diff) : diff;
  end

  logic [63:0] frac;
  assign frac = 64'(x_q[F-1:0]) << (30 - F);
  logic [63:0] e_pos;
  assign e_pos = sum_q[63] ? 64'd0 : 64'(sum_q);
  logic [63:0] eprod;
  assign eprod = e_pos[31:0] * bdot_pkg::E1_Q30;

  // Reciprocals ceil(2^34 / k) give the exact floor of a Taylor term divided by k,
  // since every product term times fraction stays below 2^30.
  logic [34:0] recip;
  always_comb begin
    unique case (k_q)
      4'd1:    recip = 35'd17179869184;
      4'd2:    recip = 35'd8589934592;
      4'd3:    recip = 35'd5726623062;
      4'd4:    recip = 35'd4294967296;
      4'd5:    recip = 35'd3435973837;
      4'd6:    recip = 35'd2863311531;
      4'd7:    recip = 35'd2454267027;
      4'd8:    recip = 35'd2147483648;
      4'd9:    recip = 35'd1908874354;
      4'd10:   recip = 35'd1717986919;
      4'd11:   recip = 35'd1561806290;
      default: recip = 35'd1431655766;
    endcase
  end
  logic [64:0] qprod;
  assign qprod = acc_q[29:0] * recip;
  logic [63:0] tnext;
  assign tnext = 64'(qprod[64:34]);

  logic signed [31:0] rawsat;
  always_comb begin
    if (neg_q) rawsat = (dquot >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dquot);
    else rawsat = (dquot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(dquot);
  end

  logic signed [63:0] bq;
  logic signed [31:0] bsat;
  always_comb begin
    bq = bl_q >>> F;
    if (bq > 64'sh7FFF_FFFF) bsat = 32'sh7FFF_FFFF;
    else if (bq < -64'sh8000_0000) bsat = 32'sh8000_0000;
    else bsat = 32'(bq);
  end

  assign in_if.ready = (state_q == S_IDLE) && !out_if.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tc_q <= '0;
      have_prev_q <= 1'b0;
      have_est_q <= 1'b0;
      prev_time_q <= '0;
      out_if.valid <= 1'b0;
      dreq.start <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_f_q[i] <= '0;
        last_s_q[i] <= '0;
      end
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we_i) tc_q <= cfg_wdata_i;
      if (out_if.valid && out_if.ready) out_if.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            item_q <= in_if.data;
            if (in_if.data.kind == bdot_pkg::KIND_CLEAR) begin
              have_prev_q <= 1'b0;
              have_est_q <= 1'b0;
              prev_time_q <= '0;
              for (int i = 0; i < 3; i++) begin
                prev_f_q[i] <= '0;
                last_s_q[i] <= '0;
              end
              out_if.data <= '{status: bdot_pkg::ST_CLEARED, default: '0};
              out_if.valid <= 1'b1;
            end else if (!have_prev_q) begin
              have_prev_q <= 1'b1;
              prev_time_q <= in_if.data.sample_time;
              prev_f_q[0] <= in_if.data.field_x;
              prev_f_q[1] <= in_if.data.field_y;
              prev_f_q[2] <= in_if.data.field_z;
              out_if.data <= '{status: bdot_pkg::ST_PRIMED,
                               estimate_time: in_if.data.sample_time, default: '0};
              out_if.valid <= 1'b1;
            end else if (in_if.data.sample_time <= prev_time_q) begin
              out_if.data <= '{status: bdot_pkg::ST_BADTIME,
                               estimate_time: in_if.data.sample_time, default: '0};
              out_if.valid <= 1'b1;
            end else begin
              ival_q <= in_if.data.sample_time - prev_time_q;
              w_q <= '0;
              ax_q <= '0;
              if (tc_q == '0) state_q <= S_RDIV;
              else begin
                dreq.start <= 1'b1;
                dreq.dividend <= 64'(in_if.data.sample_time - prev_time_q) << F;
                dreq.divisor <= tc_q;
                state_q <= S_WDIV_W;
              end
            end
          end
        end
        S_WDIV_W: if (ddone) begin
          x_q <= dquot;
          if ((dquot >> F) >= 64'd32) state_q <= S_RDIV;
          else begin
            n_q <= 6'(dquot >> F);
            term_q <= 64'(bdot_pkg::ONE_Q30);
            sum_q <= 64'(bdot_pkg::ONE_Q30);
            k_q <= 4'd1;
            state_q <= S_TAYLOR_MUL;
          end
        end
        S_TAYLOR_MUL: begin
          acc_q <= (term_q[31:0] * frac[31:0]) >> 30;
          state_q <= S_TAYLOR_DIV;
        end
        S_TAYLOR_DIV: begin
          term_q <= tnext;
          if (k_q[0]) sum_q <= sum_q - $signed(tnext);
          else sum_q <= sum_q + $signed(tnext);
          if (k_q == 4'd12) begin
            state_q <= S_EXP_MUL;
            acc_q <= '0;
          end else begin
            k_q <= k_q + 4'd1;
            state_q <= S_TAYLOR_MUL;
          end
        end
        S_EXP_MUL: begin
          if (n_q != '0) begin
            sum_q <= $signed(eprod >> 30);
            n_q <= n_q - 6'd1;
          end else begin
            w_q <= (F+1)'((e_pos + (64'(1) << (29 - F))) >> (30 - F));
            state_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          neg_q <= diff[24];
          dreq.start <= 1'b1;
          dreq.dividend <= 64'(mag) * TPS;
          dreq.divisor <= ival_q;
          state_q <= S_RDIV_W;
        end
        S_RDIV_W: if (ddone) begin
          raw_q[ax_q] <= rawsat;
          if (have_est_q) begin
            bl_q <= 64'($signed({1'b0, w_q})) * 64'(last_s_q[ax_q]);
            state_q <= S_BLEND1;
          end else begin
            sm_q[ax_q] <= rawsat;
            state_q <= S_BLEND2;
          end
        end
        S_BLEND1: begin
          bl_q <= bl_q + $signed(ONE_W - 64'(w_q)) * 64'(raw_q[ax_q])
                  + (64'sd1 <<< (F - 1));
          state_q <= S_WDIV;
        end
        S_WDIV: begin
          sm_q[ax_q] <= bsat;
          state_q <= S_BLEND2;
        end
        S_BLEND2: begin
          if (ax_q == 2'd2) state_q <= S_OUT;
          else begin
            ax_q <= ax_q + 2'd1;
            state_q <= S_RDIV;
          end
        end
        S_OUT: begin
          prev_time_q <= item_q.sample_time;
          prev_f_q[0] <= item_q.field_x;
          prev_f_q[1] <= item_q.field_y;
          prev_f_q[2] <= item_q.field_z;
          for (int i = 0; i < 3; i++) last_s_q[i] <= sm_q[i];
          have_est_q <= 1'b1;
          out_if.data <= {bdot_pkg::ST_VALID, item_q.sample_time, raw_q[0], raw_q[1],
                          raw_q[2], sm_q[0], sm_q[1], sm_q[2]};
          out_if.valid <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/bdot_div.sv
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module bdot_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdot_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [63:0]         quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_q[31:0], quot_q[63]};
    trial = shifted - {1'b0, dvs_q};
    quot_d = {quot_q[62:0], 1'b0};
    rem_d = shifted;
    if (!trial[32]) begin
      rem_d = trial;
      quot_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
        quot_q <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        quot_q <= quot_d;
        rem_q  <= rem_d;
        cnt_q  <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  assign quot_o = quot_q;
endmodule

// File: sv/bdot_chk.sv
// Port-level checker for the rate estimator, bound to the top level.
`include "bdot_rate_estimator_top_defines.svh"
module bdot_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] out_status_i
);
  // No new item is taken while a result still waits.
  `BRE_ASSERT_IMP(a_no_accept_full, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // A transfer of an input item is followed by a busy cycle.
  `BRE_ASSERT_NXT(a_busy_after, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // A stalled result keeps its status.
  `BRE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_status_i))
endmodule

bind bdot_rate_estimator_top bdot_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_status_i(out_if.data.status)
);

// File: tb/bdot_rate_estimator_checker.sv
// Checker for the field rate estimator: watches both channels, predicts each result and compares.
module bdot_rate_estimator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bdot_in_if          in_if,
  bdot_out_if         out_if,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdot_pkg::*;

  localparam longint TPS = 1000000;
  localparam int WFB = 16;

  logic [31:0]        tau;
  logic               have_prev;
  logic [31:0]        prev_time;
  logic signed [23:0] prev_field [3];
  logic               have_est;
  logic signed [31:0] last_smooth [3];
  out_item_t          expected_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  // Decay weight exp(-interval/tau) in Q1.16, built from a Q30 series and powers of exp(-1).
  function automatic logic [63:0] decay_weight(logic [31:0] interval, logic [31:0] tc);
    logic [63:0] x, n, frac, term, e;
    longint      sum;
    if (tc == 0) return 64'd0;
    x = ({32'd0, interval} << WFB) / {32'd0, tc};
    n = x >> WFB;
    if (n >= 32) return 64'd0;
    frac = (x & ((64'd1 << WFB) - 1)) << (30 - WFB);
    term = {32'd0, ONE_Q30};
    sum  = longint'(ONE_Q30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * frac) >> 30) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    for (int i = 0; i < n; i++) e = (e * {32'd0, E1_Q30}) >> 30;
    return (e + (64'd1 << (29 - WFB))) >> (30 - WFB);
  endfunction

  function automatic logic signed [31:0] axis_rate(logic signed [23:0] now,
                                                   logic signed [23:0] was,
                                                   logic [31:0] interval);
    longint      diff;
    logic [63:0] mag;
    diff = longint'(now) - longint'(was);
    mag  = 64'(diff < 0 ? -diff : diff);
    mag  = mag * 64'(TPS) / {32'd0, interval};
    if (diff < 0) return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -32'(mag);
    return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
  endfunction

  function automatic logic signed [31:0] blend_rate(logic [63:0] w, logic signed [31:0] last,
                                                    logic signed [31:0] raw);
    longint t;
    t = longint'(w) * longint'(last) + ((longint'(1) << WFB) - longint'(w)) * longint'(raw)
        + (longint'(1) << (WFB - 1));
    t = t >>> WFB;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return 32'(t);
  endfunction

  // Advances the predicted state by one input and returns its result.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t          r;
    logic signed [23:0] f [3];
    logic signed [31:0] raw [3];
    logic signed [31:0] sm [3];
    logic [63:0]        w;
    logic [31:0]        interval;
    r = '0;
    if (it.kind == KIND_CLEAR) begin
      have_prev = 1'b0;
      prev_time = '0;
      have_est  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_field[i]  = '0;
        last_smooth[i] = '0;
      end
      r.status = ST_CLEARED;
      return r;
    end
    r.estimate_time = it.sample_time;
    f[0] = it.field_x;
    f[1] = it.field_y;
    f[2] = it.field_z;
    if (!have_prev) begin
      have_prev = 1'b1;
      prev_time = it.sample_time;
      for (int i = 0; i < 3; i++) prev_field[i] = f[i];
      r.status = ST_PRIMED;
      return r;
    end
    if (it.sample_time <= prev_time) begin
      r.status = ST_BADTIME;
      return r;
    end
    interval = it.sample_time - prev_time;
    w = decay_weight(interval, tau);
    for (int i = 0; i < 3; i++) begin
      raw[i] = axis_rate(f[i], prev_field[i], interval);
      sm[i]  = have_est ? blend_rate(w, last_smooth[i], raw[i]) : raw[i];
      prev_field[i]  = f[i];
      last_smooth[i] = sm[i];
    end
    prev_time = it.sample_time;
    have_est  = 1'b1;
    r.status = ST_VALID;
    r.raw_rate_x = raw[0];
    r.raw_rate_y = raw[1];
    r.raw_rate_z = raw[2];
    r.smooth_rate_x = sm[0];
    r.smooth_rate_y = sm[1];
    r.smooth_rate_z = sm[2];
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      tau       = '0;
      have_prev = 1'b0;
      prev_time = '0;
      have_est  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_field[i]  = '0;
        last_smooth[i] = '0;
      end
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) tau = cfg_wdata_i;
      if (in_if.valid && in_if.ready) expected_q.push_back(predict_result(in_if.data));
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected result", 64'(got.status), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.estimate_time != want.estimate_time)
            flag_mismatch("estimate_time", 64'(got.estimate_time), 64'(want.estimate_time));
          if (got.raw_rate_x != want.raw_rate_x)
            flag_mismatch("raw_rate_x", 64'(got.raw_rate_x), 64'(want.raw_rate_x));
          if (got.raw_rate_y != want.raw_rate_y)
            flag_mismatch("raw_rate_y", 64'(got.raw_rate_y), 64'(want.raw_rate_y));
          if (got.raw_rate_z != want.raw_rate_z)
            flag_mismatch("raw_rate_z", 64'(got.raw_rate_z), 64'(want.raw_rate_z));
          if (got.smooth_rate_x != want.smooth_rate_x)
            flag_mismatch("smooth_rate_x", 64'(got.smooth_rate_x), 64'(want.smooth_rate_x));
          if (got.smooth_rate_y != want.smooth_rate_y)
            flag_mismatch("smooth_rate_y", 64'(got.smooth_rate_y), 64'(want.smooth_rate_y));
          if (got.smooth_rate_z != want.smooth_rate_z)
            flag_mismatch("smooth_rate_z", 64'(got.smooth_rate_z), 64'(want.smooth_rate_z));
        end
      end
    end
  end
endmodule

// File: tb/bdot_rate_estimator_top_tb.sv
// Testbench top of the field rate estimator: drives stimulus, idling and configuration.
module bdot_rate_estimator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdot_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold_req = 1'b0;
  int          hold_left = 0;
  logic [31:0] last_time = '0;
  logic signed [23:0] last_field [3];

  bdot_in_if  in_if ();
  bdot_out_if out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  bdot_rate_estimator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if), .out_if(out_if)
  );

  bdot_rate_estimator_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if), .out_if(out_if), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side; a long hold-off lets the block fill up and stall its input.
  always @(posedge clk_i) begin
    if (long_hold_req && hold_left == 0) begin
      long_hold_req <= 1'b0;
      hold_left <= 3000;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_sample(logic [31:0] t, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z);
    in_item_t it;
    it.kind = KIND_SAMPLE;
    it.sample_time = t;
    it.field_x = x;
    it.field_y = y;
    it.field_z = z;
    send_item(it);
  endtask

  task automatic send_clear();
    in_item_t it;
    it = '0;
    it.kind = KIND_CLEAR;
    it.sample_time = $urandom();
    it.field_x = $urandom();
    it.field_y = $urandom();
    it.field_z = $urandom();
    send_item(it);
  endtask

  // Lowers valid, drains all results, then writes the time constant.
  task automatic set_time_constant(logic [31:0] tc);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [23:0] next_field(logic signed [23:0] prev);
    case ($urandom_range(7, 0))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return 24'($urandom());
      default: return prev + 24'($urandom_range(2000, 0)) - 24'sd1000;
    endcase
  endfunction

  // Mostly increasing timestamps with occasional clears and stale times.
  task automatic random_item();
    int          pick;
    logic [31:0] step;
    logic signed [23:0] f [3];
    pick = $urandom_range(99, 0);
    if (pick < 4) begin
      send_clear();
      last_time = $urandom();
      return;
    end
    for (int i = 0; i < 3; i++) f[i] = next_field(last_field[i]);
    if (pick < 10) begin
      step = (pick < 6) ? 32'd0 : 32'($urandom_range(5000, 1));
      send_sample(last_time - step, f[0], f[1], f[2]);
      return;
    end
    case ($urandom_range(3, 0))
      0: step = $urandom_range(20, 1);
      1: step = $urandom_range(5000, 1);
      2: step = $urandom_range(2000000, 1);
      default: step = $urandom();
    endcase
    if ({1'b0, last_time} + {1'b0, step} > 33'hFFFF_FFFF) begin
      // Would wrap past the top of the time range; restart the stream.
      send_clear();
      last_time = $urandom_range(1000, 0);
      return;
    end
    last_time = last_time + step;
    for (int i = 0; i < 3; i++) last_field[i] = f[i];
    send_sample(last_time, f[0], f[1], f[2]);
  endtask

  initial begin
    logic [31:0] tc_list [6];
    int          idle_list [6];
    int          stall_list [6];
    for (int i = 0; i < 3; i++) last_field[i] = '0;
    tc_list = '{32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd50000, 32'd0, 32'd0};
    idle_list = '{0, 85, 0, 32, 0, 85};
    stall_list = '{0, 0, 85, 32, 0, 85};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with smoothing disabled.
    send_sample(32'd0, 24'sh7FFFFF, 24'sh800000, 24'sd0);
    send_sample(32'd0, 24'sd1, 24'sd1, 24'sd1);
    send_sample(32'd1, 24'sh800000, 24'sh7FFFFF, 24'sd0);
    send_sample(32'd2, 24'sh7FFFFF, 24'sh800000, 24'sd5);
    send_sample(32'd1000002, 24'sd100, -24'sd100, 24'sd5);
    send_clear();
    send_sample(32'hFFFF_FFFF, 24'sd3, 24'sd3, 24'sd3);
    send_sample(32'd5, 24'sd3, 24'sd3, 24'sd3);
    send_sample(32'hFFFF_FFFE, 24'sd0, 24'sd0, 24'sd0);
    send_clear();
    send_sample(32'd100, 24'sd0, 24'sd0, 24'sd0);
    send_sample(32'd1000100, 24'sd7, -24'sd7, 24'sd1);
    send_sample(32'd1000103, -24'sd9, 24'sd9, 24'sd0);
    send_sample(32'hFFFF_FFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);

    // Maximal constant: after the first estimate, every short step keeps the previous smoothed rate.
    set_time_constant(32'hFFFF_FFFF);
    send_clear();
    send_sample(32'd10, 24'sd0, 24'sd0, 24'sd0);
    send_sample(32'd11, 24'sd500, -24'sd500, 24'sd1);
    send_sample(32'd12, -24'sd500, 24'sd500, 24'sd2);
    send_sample(32'hFFFF_FFF0, 24'sh800000, 24'sh7FFFFF, 24'sd2);
    set_time_constant(32'd1);
    send_sample(32'hFFFF_FFF5, 24'sd10, 24'sd10, 24'sd10);
    send_sample(32'hFFFF_FFFF, 24'sd20, 24'sd0, 24'sd10);
    send_clear();
    last_time = '0;

    for (int ph = 0; ph < 6; ph++) begin
      set_time_constant(tc_list[ph]);
      send_idle_pct = idle_list[ph];
      recv_stall_pct = stall_list[ph];
      for (int n = 0; n < 305; n++) begin
        if (ph == 4 && n == 20) long_hold_req <= 1'b1;
        random_item();
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
